/* hw/rtl/bslp_pkg.sv */
// ----------------------------------------------------------------------------
// bslp_pkg: shared types and constants for the button press detector
// Holds the press phase codes, event kinds, register indexes and the
// configuration and event structs passed between the core and the top level.
// ----------------------------------------------------------------------------
package bslp_pkg;

  localparam int unsigned LongMsW  = 16;
  localparam int unsigned DebW     = 4;
  localparam int unsigned TimeW    = 32;
  localparam int unsigned CfgIdxW  = 1;
  localparam int unsigned CfgDataW = 16;

  // register indexes of the configuration port
  localparam logic [CfgIdxW-1:0] REG_LONG_PRESS_MS  = 1'd0;
  localparam logic [CfgIdxW-1:0] REG_DEBOUNCE_SCANS = 1'd1;

  // register reset values
  localparam logic [LongMsW-1:0] LONG_PRESS_MS_RST  = 16'd1000;
  localparam logic [DebW-1:0]    DEBOUNCE_SCANS_RST = 4'd3;

  // event kinds
  localparam logic KIND_SHORT = 1'b0;
  localparam logic KIND_LONG  = 1'b1;

  // pin levels
  localparam logic LEVEL_PRESSED  = 1'b0;
  localparam logic LEVEL_RELEASED = 1'b1;

  typedef enum logic [2:0] {
    PHASE_IDLE    = 3'b001,
    PHASE_PRESSED = 3'b010,
    PHASE_LONG    = 3'b100
  } phase_t;

  typedef struct packed {
    logic [LongMsW-1:0] long_press_ms;
    logic [DebW-1:0]    debounce_scans;
  } cfg_t;

  typedef struct packed {
    logic valid;
    logic kind;
  } evt_t;

endpackage

/* hw/rtl/button_short_long_press_detector.sv */
// ----------------------------------------------------------------------------
// button_short_long_press_detector: debounced short and long press events
// Top level with configuration registers, the press core and an output
// buffer with a skid entry.
// ----------------------------------------------------------------------------
// Usage
//   in_*  : one scan word per handshake: pin level (0 pressed) and ms time.
//   out_* : one event word per detected press: press_kind 0 short, 1 long.
//   cfg_* : write port, index 0 long_press_ms, index 1 debounce_scans;
//           write only while no scan is in flight.
// Timing
//   A scan is evaluated in the cycle it is taken; its event word is registered
//   on out_valid or parked in the skid entry. One scan per cycle is taken as
//   long as the output side keeps up; the rate is set by the single state
//   update per cycle in the press core.
// Stall
//   When the receiver holds out_ready low, one more event word is parked in
//   the skid entry; in_ready drops only while that entry is occupied.
// Reset
//   rst_n low (synchronous) restores register defaults, clears the press
//   state, marks the next scan as the first one and empties the buffer.
// ----------------------------------------------------------------------------
module button_short_long_press_detector import bslp_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic                in_key_level,
  input  logic [TimeW-1:0]    in_now_ms,
  output logic                out_valid,
  input  logic                out_ready,
  output logic                out_press_kind,
  input  logic                cfg_we,
  input  logic [CfgIdxW-1:0]  cfg_index,
  input  logic [CfgDataW-1:0] cfg_data
);

  cfg_t cfg_r;
  evt_t evt;
  logic scan_fire;
  logic pop;

  logic out_valid_r, skid_valid_r;
  logic out_kind_r, skid_kind_r;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.long_press_ms  <= LONG_PRESS_MS_RST;
      cfg_r.debounce_scans <= DEBOUNCE_SCANS_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_LONG_PRESS_MS:  cfg_r.long_press_ms  <= cfg_data[LongMsW-1:0];
        REG_DEBOUNCE_SCANS: cfg_r.debounce_scans <= cfg_data[DebW-1:0];
        default: ;
      endcase
    end
  end

  assign in_ready  = !skid_valid_r;
  assign scan_fire = in_valid && in_ready;
  assign pop       = out_valid_r && out_ready;

  bslp_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .scan_fire (scan_fire),
    .key_level (in_key_level),
    .now_ms    (in_now_ms),
    .cfg       (cfg_r),
    .evt       (evt)
  );

  // output register with skid entry
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (skid_valid_r) begin
      if (pop) begin
        out_valid_r  <= 1'b1;
        skid_valid_r <= 1'b0;
      end
    end else if (evt.valid) begin
      if (!out_valid_r || pop) begin
        out_valid_r <= 1'b1;
      end else begin
        skid_valid_r <= 1'b1;
      end
    end else if (pop) begin
      out_valid_r <= 1'b0;
    end
  end

  // payload of the buffer
  always_ff @(posedge clk) begin
    if (skid_valid_r) begin
      if (pop) begin
        out_kind_r <= skid_kind_r;
      end
    end else if (evt.valid) begin
      if (!out_valid_r || pop) begin
        out_kind_r <= evt.kind;
      end else begin
        skid_kind_r <= evt.kind;
      end
    end
  end

  assign out_valid      = out_valid_r;
  assign out_press_kind = out_kind_r;

  // buffer checks
  a_skid_needs_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid entry holds a word while output register is empty");

  a_skid_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (skid_valid_r && !out_ready) |=> (skid_valid_r && $stable(skid_kind_r)))
    else $error("skid entry lost or changed while output stalled");

  a_stall_parks: assert property (@(posedge clk) disable iff (!rst_n)
    (evt.valid && out_valid_r && !out_ready) |=> skid_valid_r)
    else $error("event during output stall was not parked");

endmodule

/* hw/rtl/bslp_core.sv */
// ----------------------------------------------------------------------------
// bslp_core: debounce and press timing state
// Updates the debounce and press state for every scan word taken and
// reports at most one press event in the same cycle.
// ----------------------------------------------------------------------------
module bslp_core import bslp_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             scan_fire,
  input  logic             key_level,
  input  logic [TimeW-1:0] now_ms,
  input  cfg_t             cfg,
  output evt_t             evt
);

  logic             first_scan_r, first_scan_nxt;
  logic             stable_level_r, stable_level_nxt;
  logic [DebW-1:0]  change_count_r, change_count_nxt;
  phase_t           phase_r, phase_nxt;
  logic [TimeW-1:0] press_start_r, press_start_nxt;

  logic [DebW-1:0]  count_inc;
  logic [TimeW-1:0] held;
  logic             held_long;

  assign count_inc = change_count_r + DebW'(1);
  assign held      = now_ms - press_start_r;
  assign held_long = held > {{(TimeW-LongMsW){1'b0}}, cfg.long_press_ms};

  // next state and event for one scan
  always_comb begin
    first_scan_nxt   = first_scan_r;
    stable_level_nxt = stable_level_r;
    change_count_nxt = change_count_r;
    phase_nxt        = phase_r;
    press_start_nxt  = press_start_r;
    evt.valid        = 1'b0;
    evt.kind         = KIND_SHORT;
    if (scan_fire) begin
      if (first_scan_r) begin
        stable_level_nxt = key_level;
        first_scan_nxt   = 1'b0;
      end else if (key_level != stable_level_r) begin
        change_count_nxt = count_inc;
        if (count_inc >= cfg.debounce_scans) begin
          change_count_nxt = '0;
          stable_level_nxt = key_level;
          if (key_level == LEVEL_PRESSED) begin
            phase_nxt       = PHASE_PRESSED;
            press_start_nxt = now_ms;
          end else begin
            phase_nxt = PHASE_IDLE;
            if (phase_r == PHASE_PRESSED) begin
              evt.valid = 1'b1;
              evt.kind  = KIND_SHORT;
            end
          end
        end
      end else begin
        change_count_nxt = '0;
        if (key_level == LEVEL_PRESSED && phase_r == PHASE_PRESSED && held_long) begin
          press_start_nxt = now_ms;
          phase_nxt       = PHASE_LONG;
          evt.valid       = 1'b1;
          evt.kind        = KIND_LONG;
        end
      end
    end
  end

  // state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      first_scan_r   <= 1'b1;
      stable_level_r <= LEVEL_RELEASED;
      change_count_r <= '0;
      phase_r        <= PHASE_IDLE;
      press_start_r  <= '0;
    end else begin
      first_scan_r   <= first_scan_nxt;
      stable_level_r <= stable_level_nxt;
      change_count_r <= change_count_nxt;
      phase_r        <= phase_nxt;
      press_start_r  <= press_start_nxt;
    end
  end

endmodule

/* tb/sv/button_short_long_press_detector_test.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// button_short_long_press_detector_test: self-checking bench for the detector
// Drives pin scans through the valid/ready input, predicts debounce and press
// events in a scoreboard class and compares every event word in order. Runs
// through several register settings, including the extremes, with random
// gaps and output stalls.
// ----------------------------------------------------------------------------
module button_short_long_press_detector_test;
  import bslp_pkg::*;

  localparam int unsigned STALL_LIMIT = 2000;

  // press predictor with its own register and state copy
  class press_event_checker;
    logic [LongMsW-1:0] long_ms;
    logic [DebW-1:0]    deb_scans;
    bit                 first_pending;
    logic               stable_lvl;
    logic [DebW-1:0]    diff_count;
    phase_t             phase;
    logic [TimeW-1:0]   press_t0;
    logic               expected_kinds[$];
    int unsigned        fail_count;

    function void clear();
      long_ms       = LONG_PRESS_MS_RST;
      deb_scans     = DEBOUNCE_SCANS_RST;
      first_pending = 1'b1;
      stable_lvl    = LEVEL_RELEASED;
      diff_count    = '0;
      phase         = PHASE_IDLE;
      press_t0      = '0;
      expected_kinds.delete();
    endfunction

    function void write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] data);
      case (idx)
        REG_LONG_PRESS_MS:  long_ms = data[LongMsW-1:0];
        REG_DEBOUNCE_SCANS: deb_scans = data[DebW-1:0];
        default: ;
      endcase
    endfunction

    function int pending();
      return expected_kinds.size();
    endfunction

    // one accepted scan word
    function void note_scan(logic lvl, logic [TimeW-1:0] t);
      logic [TimeW-1:0] held;
      // first scan only records the level
      if (first_pending) begin
        stable_lvl    = lvl;
        first_pending = 1'b0;
        return;
      end
      // differing level: count toward acceptance
      if (lvl != stable_lvl) begin
        diff_count = diff_count + 1'b1;
        if (diff_count >= deb_scans) begin
          diff_count = '0;
          stable_lvl = lvl;
          if (lvl == LEVEL_PRESSED) begin
            phase    = PHASE_PRESSED;
            press_t0 = t;
          end else begin
            if (phase == PHASE_PRESSED) expected_kinds.push_back(KIND_SHORT);
            phase = PHASE_IDLE;
          end
        end
        return;
      end
      // stable level: check the hold time
      diff_count = '0;
      if (lvl == LEVEL_PRESSED && phase == PHASE_PRESSED) begin
        held = t - press_t0;
        if (held > long_ms) begin
          press_t0 = t;
          phase    = PHASE_LONG;
          expected_kinds.push_back(KIND_LONG);
        end
      end
    endfunction

    // one accepted event word
    function void check_event(logic kind);
      logic want;
      if (expected_kinds.size() == 0) begin
        $error("press_kind: expected no word, actual %0d", kind);
        fail_count++;
        return;
      end
      want = expected_kinds.pop_front();
      if (kind !== want) begin
        $error("press_kind: expected %0d, actual %0d", want, kind);
        fail_count++;
      end
    endfunction
  endclass

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_key_level = LEVEL_RELEASED;
  logic [TimeW-1:0]    in_now_ms = '0;
  logic                out_ready = 1'b0;
  logic                cfg_we = 1'b0;
  logic [CfgIdxW-1:0]  cfg_index = REG_LONG_PRESS_MS;
  logic [CfgDataW-1:0] cfg_data = '0;
  logic                in_ready;
  logic                out_valid;
  logic                out_press_kind;

  press_event_checker chk = new();
  bit                 calm = 1'b0;
  logic [TimeW-1:0]   clock_ms = '0;
  int unsigned        scans_sent = 0;
  int unsigned        quiet_cycles = 0;

  initial begin
    forever #5 clk = ~clk;
  end

  button_short_long_press_detector u_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_key_level   (in_key_level),
    .in_now_ms      (in_now_ms),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_press_kind (out_press_kind),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  // event side: check accepted words, stall at random
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) chk.check_event(out_press_kind);
    out_ready <= calm || ($urandom_range(99) >= 22);
  end

  // watchdog on cycles without any handshake
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == STALL_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic logic [TimeW-1:0] tick();
    clock_ms += $urandom_range(0, 40);
    return clock_ms;
  endfunction

  // send one scan word, with an optional gap ahead of it
  task automatic scan(input logic lvl, input logic [TimeW-1:0] t);
    while (!calm && $urandom_range(99) < 22) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_key_level <= lvl;
    in_now_ms    <= t;
    do @(posedge clk); while (!in_ready);
    chk.note_scan(lvl, t);
    scans_sent++;
  endtask

  // stop sending and wait for all events to come out
  task automatic drain(input int unsigned extra);
    in_valid <= 1'b0;
    while (chk.pending() != 0) @(posedge clk);
    repeat (extra) @(posedge clk);
  endtask

  // write both registers; junk in the unused upper data bits
  task automatic set_config(input logic [LongMsW-1:0] lp, input logic [DebW-1:0] db);
    logic [CfgDataW-1:0] deb_word;
    deb_word = {CfgDataW'($urandom)} & ~CfgDataW'({DebW{1'b1}});
    deb_word = deb_word | CfgDataW'(db);
    cfg_we    <= 1'b1;
    cfg_index <= REG_LONG_PRESS_MS;
    cfg_data  <= lp;
    @(posedge clk);
    chk.write_reg(REG_LONG_PRESS_MS, lp);
    cfg_index <= REG_DEBOUNCE_SCANS;
    cfg_data  <= deb_word;
    @(posedge clk);
    chk.write_reg(REG_DEBOUNCE_SCANS, deb_word);
    cfg_we <= 1'b0;
  endtask

  // fixed sequence under reset defaults
  task automatic directed();
    // first scan pressed, then a release with nothing pending
    scan(LEVEL_PRESSED, 32'd0);
    scan(LEVEL_RELEASED, 32'd1); scan(LEVEL_RELEASED, 32'd2); scan(LEVEL_RELEASED, 32'd3);
    // press, hold exactly the limit, then one past it
    scan(LEVEL_PRESSED, 32'd100); scan(LEVEL_PRESSED, 32'd101); scan(LEVEL_PRESSED, 32'd102);
    scan(LEVEL_PRESSED, 32'd1102); scan(LEVEL_PRESSED, 32'd1103);
    scan(LEVEL_PRESSED, 32'hFFFF_FFFF);
    // release after a long press is silent
    scan(LEVEL_RELEASED, 32'd5000); scan(LEVEL_RELEASED, 32'd5001);
    scan(LEVEL_RELEASED, 32'd5002);
    // bounce clears the count
    scan(LEVEL_PRESSED, 32'd6000); scan(LEVEL_RELEASED, 32'd6001);
    // short press across the time wrap
    scan(LEVEL_PRESSED, 32'hFFFF_FF00); scan(LEVEL_PRESSED, 32'hFFFF_FF01);
    scan(LEVEL_PRESSED, 32'hFFFF_FF02); scan(LEVEL_PRESSED, 32'h0000_0010);
    scan(LEVEL_RELEASED, 32'h20); scan(LEVEL_RELEASED, 32'h21); scan(LEVEL_RELEASED, 32'h22);
    clock_ms = 32'h100;
  endtask

  // press and release with optional bounce and a chosen hold time
  task automatic press_episode();
    int unsigned      deb_eff;
    int unsigned      n;
    longint unsigned  hold;
    logic [TimeW-1:0] t0;
    deb_eff = (chk.deb_scans == 0) ? 1 : chk.deb_scans;
    repeat ($urandom_range(0, 2)) scan(LEVEL_RELEASED, tick());
    if ($urandom_range(3) == 0) begin
      scan(LEVEL_PRESSED, tick());
      scan(LEVEL_RELEASED, tick());
    end
    repeat (deb_eff) scan(LEVEL_PRESSED, tick());
    t0 = clock_ms;
    case ($urandom_range(5))
      0:       hold = $urandom_range(0, chk.long_ms);
      1:       hold = chk.long_ms;
      2:       hold = chk.long_ms + 1;
      3:       hold = chk.long_ms + $urandom_range(1, 3 * chk.long_ms + 10);
      4:       hold = 0;
      default: hold = $urandom;
    endcase
    n = $urandom_range(1, 5);
    for (int i = 1; i <= n; i++) begin
      clock_ms = t0 + TimeW'(hold * i / n);
      scan(LEVEL_PRESSED, clock_ms);
    end
    if ($urandom_range(3) == 0) begin
      scan(LEVEL_RELEASED, tick());
      scan(LEVEL_PRESSED, tick());
    end
    repeat (deb_eff) scan(LEVEL_RELEASED, tick());
  endtask

  // random levels, sometimes with a jump in time
  task automatic noise_burst();
    repeat ($urandom_range(1, 6)) begin
      if ($urandom_range(1) == 0) clock_ms = $urandom;
      scan(logic'($urandom_range(1)), tick());
    end
  endtask

  // main sequence
  initial begin
    int unsigned phase_end;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    chk.clear();
    directed();
    drain(4);
    for (int p = 0; p < 8; p++) begin
      case (p)
        0:       set_config(16'd0, 4'd0);
        1:       set_config(16'hFFFF, 4'hF);
        2:       set_config(16'd1, 4'd1);
        3:       set_config(LONG_PRESS_MS_RST, DEBOUNCE_SCANS_RST);
        default: set_config(LongMsW'($urandom_range(1) ? $urandom_range(1, 3000)
                                                       : $urandom_range(0, 65535)),
                            DebW'($urandom_range(0, 15)));
      endcase
      // one phase without gaps or stalls
      calm = (p == 3);
      if (p == 4) clock_ms = 32'hFFFF_F000;
      phase_end = scans_sent + 216;
      while (scans_sent < phase_end) begin
        if ($urandom_range(99) < 80) press_episode();
        else noise_burst();
      end
      drain(4);
    end
    if (chk.fail_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
